@@ hdl/hbq_pkg.sv @@
package hbq_pkg;

    // Default number of entries the heap can hold.
    localparam int DEFAULT_DEPTH = 128;

    // Stack keys count down from this base so the newest entry has the least key.
    localparam logic [31:0] STACK_KEY_BASE = 32'h00FF_FFFF;

    // Operation codes carried in the op field.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Order mode codes.
    localparam logic MODE_QUEUE = 1'b0;
    localparam logic MODE_STACK = 1'b1;

    // Status codes returned with every result.
    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

    typedef struct packed {
        logic               op;
        logic signed [31:0] push_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
        logic [7:0]         fill_count;
    } t_out;

    // One stored heap entry.
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
    } t_entry;

endpackage

@@ hdl/hbq_ram.sv @@
module hbq_ram #(
    parameter int DEPTH = hbq_pkg::DEFAULT_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  hbq_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr_a,
    input  logic [AW-1:0]   i_raddr_b,
    output hbq_pkg::t_entry o_rdata_a,
    output hbq_pkg::t_entry o_rdata_b
);
    import hbq_pkg::*;

    // Entry storage: one write port, two read ports with registered data.
    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ hdl/heap_backed_queue_or_stack_top.sv @@
// Binary min-heap of key/value entries that behaves as a FIFO queue or a LIFO
// stack, selected by the one-bit order mode register (0 queue, 1 stack). A push
// derives a key (a running insertion sequence in queue mode, 0xFFFFFF minus the
// new fill count in stack mode), stores the entry and sifts it up; a pop returns
// the root value, moves the last entry to the root and sifts it down. Every
// input transfer yields exactly one output transfer carrying the popped value,
// a status code and the fill count. The block works on one operation at a time.
// A push steps from the idle state through one sift-up state per level climbed
// (and a place state when the entry reaches the root) to the done state, which
// loads the output register; a pop steps through a load state and one sift-down
// state per level descended to the done state, skipping the sift when it empties
// the heap. Each sift level is one engine step because every step needs a read
// of the entry memory, whose read data is registered. Errors (pop on empty, push
// on full) go straight to the done state. The engine returns to idle before it
// takes the next input transfer; a result that waits in the output register
// holds the engine in its done state for as long as it waits. A new input
// transfer is taken whenever the engine is idle, even while the previous result
// still sits in the output register waiting to be taken.
module heap_backed_queue_or_stack_top #(
    parameter int DEPTH = hbq_pkg::DEFAULT_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hbq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hbq_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);
    import hbq_pkg::*;

    // Address width, count width (holds DEPTH itself) and child index width.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = AW + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_LOAD,
        S_UP,
        S_DOWN,
        S_PLACE,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [31:0]        r_seq;
    logic               r_mode;
    logic [AW-1:0]      r_pos;
    t_entry             r_move;
    logic signed [31:0] r_pop_value;
    logic [1:0]         r_status;
    logic               r_out_valid;
    t_out               r_out;

    // Memory ports.
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_entry        w_wdata;
    logic [AW-1:0] w_raddr_a;
    logic [AW-1:0] w_raddr_b;
    t_entry        w_rdata_a;
    t_entry        w_rdata_b;

    hbq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    logic w_accept;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Push bookkeeping: the new entry lands in the first free slot.
    logic          w_full;
    logic          w_empty;
    logic [AW-1:0] w_slot;
    logic [AW-1:0] w_slot_parent;
    logic [CW-1:0] w_new_count;
    logic [31:0]   w_new_key;

    assign w_full        = (r_count >= CW'(DEPTH));
    assign w_empty       = (r_count == '0);
    assign w_slot        = r_count[AW-1:0];
    assign w_slot_parent = (w_slot - 1'b1) >> 1;
    assign w_new_count   = r_count + 1'b1;
    assign w_new_key     = (r_mode == MODE_STACK) ? (STACK_KEY_BASE - 32'(w_new_count))
                                                  : (r_seq + 32'd1);

    // Sift-up step: memory port A holds the parent of the hole at r_pos.
    logic [AW-1:0] w_parent;
    logic [AW-1:0] w_grand;
    logic          w_up_stop;

    assign w_parent  = (r_pos - 1'b1) >> 1;
    assign w_grand   = (w_parent - 1'b1) >> 1;
    assign w_up_stop = (w_rdata_a.key <= r_move.key);

    // Sift-down step: ports A and B hold the left and right children of r_pos.
    // The left child wins a tie between children; a child moves up only when
    // its key is strictly less than the entry being sifted.
    logic [LW-1:0] w_left;
    logic [LW-1:0] w_right;
    logic          w_sel_l;
    logic          w_sel_r;
    logic [31:0]   w_cur_key;
    logic [AW-1:0] w_child;
    t_entry        w_child_entry;
    logic [AW:0]   w_gleft;
    logic [AW:0]   w_gright;

    always_comb begin
        w_left        = {1'b0, r_pos, 1'b1};
        w_right       = w_left + 1'b1;
        w_sel_l       = (w_left < LW'(r_count)) && (w_rdata_a.key < r_move.key);
        w_cur_key     = w_sel_l ? w_rdata_a.key : r_move.key;
        w_sel_r       = (w_right < LW'(r_count)) && (w_rdata_b.key < w_cur_key);
        w_child       = w_sel_r ? w_right[AW-1:0] : w_left[AW-1:0];
        w_child_entry = w_sel_r ? w_rdata_b : w_rdata_a;
        // Children of the chosen child; out-of-range addresses are read but
        // their data is ignored by the bound checks above.
        w_gleft       = {w_child, 1'b1};
        w_gright      = w_gleft + 1'b1;
    end

    // Read addresses are issued in the cycle before the step that consumes them.
    always_comb begin
        w_raddr_a = '0;
        w_raddr_b = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_data.op == OP_POP) begin
                    w_raddr_a = AW'(r_count - 1'b1);
                end else begin
                    w_raddr_a = w_slot_parent;
                end
            end
            S_POP_LOAD: begin
                w_raddr_a = AW'(1);
                w_raddr_b = AW'(2);
            end
            S_UP: begin
                w_raddr_a = w_grand;
            end
            S_DOWN: begin
                w_raddr_a = w_gleft[AW-1:0];
                w_raddr_b = w_gright[AW-1:0];
            end
            default: begin
                w_raddr_a = '0;
                w_raddr_b = '0;
            end
        endcase
    end

    // The sifted entry stays in r_move while displaced entries are written
    // into the hole; the hole never coincides with a pending read address.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_move;
        unique case (r_state)
            S_UP: begin
                w_we    = 1'b1;
                w_wdata = w_up_stop ? r_move : w_rdata_a;
            end
            S_DOWN: begin
                w_we    = 1'b1;
                w_wdata = (w_sel_l || w_sel_r) ? w_child_entry : r_move;
            end
            S_PLACE: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_seq       <= '0;
            r_mode      <= MODE_QUEUE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pop_value <= '0;
                        r_status    <= ST_DONE;
                        if (i_in_data.op == OP_PUSH) begin
                            if (w_full) begin
                                r_status <= ST_PUSH_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                r_count      <= w_new_count;
                                r_seq        <= r_seq + 32'd1;
                                r_move.key   <= w_new_key;
                                r_move.value <= i_in_data.push_value;
                                r_pos        <= w_slot;
                                r_state      <= (w_slot == '0) ? S_PLACE : S_UP;
                            end
                        end else begin
                            if (w_empty) begin
                                r_status <= ST_POP_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_count <= r_count - 1'b1;
                                r_state <= S_POP_LOAD;
                            end
                        end
                    end
                end
                S_POP_LOAD: begin
                    // Port A returns the last entry, port B the root.
                    r_pop_value <= w_rdata_b.value;
                    r_move      <= w_rdata_a;
                    r_pos       <= '0;
                    if (r_count == '0) begin
                        r_seq   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DOWN;
                    end
                end
                S_UP: begin
                    if (w_up_stop) begin
                        r_state <= S_DONE;
                    end else begin
                        r_pos   <= w_parent;
                        r_state <= (w_parent == '0) ? S_PLACE : S_UP;
                    end
                end
                S_DOWN: begin
                    if (w_sel_l || w_sel_r) begin
                        r_pos <= w_child;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_PLACE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid      <= 1'b1;
                        r_out.pop_value  <= r_pop_value;
                        r_out.status     <= r_status;
                        r_out.fill_count <= 8'(r_count);
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
